### hdl/ibad_pkg.sv
package ibad_pkg;

  localparam int unsigned PixW       = 8;
  localparam int unsigned WidthW     = 11;
  localparam int unsigned HeightW    = 13;
  localparam int unsigned ScaleW     = 5;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 13;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned MaxScale   = 16;
  localparam int unsigned MaxOutCols = 64;

  localparam int unsigned ColW       = 10;  // col_position
  localparam int unsigned RowW       = 12;  // row_position
  localparam int unsigned SubW       = 4;   // sub_col / sub_row
  localparam int unsigned RunW       = 12;  // horizontal run sum
  localparam int unsigned SumW       = 16;  // block column sum
  localparam int unsigned ColIdxW    = $clog2(MaxOutCols);
  localparam int unsigned OutColW    = $clog2(MaxOutCols + 1);

  // Quotient by reciprocal: q = (x * ceil(2^K / d)) >> K, exact over the used ranges
  localparam int unsigned RecipK     = 17;
  localparam int unsigned RecipW     = 18;
  localparam int unsigned AvgK       = 24;
  localparam int unsigned AvgRecipW  = 25;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegScale  = 2'd2;

  localparam logic [WidthW-1:0]  WidthReset  = 11'd1024;
  localparam logic [HeightW-1:0] HeightReset = 13'd1024;
  localparam logic [ScaleW-1:0]  ScaleReset  = 5'd2;

  typedef struct packed {
    logic [WidthW-1:0]  width;
    logic [HeightW-1:0] height;
    logic [ScaleW-1:0]  scale;
  } cfg_t;

  typedef struct packed {
    logic            vld;
    logic [PixW-1:0] pix;
    logic            last;
  } res_t;

  function automatic logic [ScaleW-1:0] clamp_scale(input logic [ScaleW-1:0] v);
    logic [ScaleW-1:0] r;
    if (v == '0) r = ScaleW'(1);
    else if (v > ScaleW'(MaxScale)) r = ScaleW'(MaxScale);
    else r = v;
    return r;
  endfunction

  function automatic logic [WidthW-1:0] clamp_width(input logic [WidthW-1:0] v);
    logic [WidthW-1:0] r;
    if (v == '0) r = WidthW'(1);
    else if (v > WidthW'(MaxWidth)) r = WidthW'(MaxWidth);
    else r = v;
    return r;
  endfunction

  function automatic logic [HeightW-1:0] clamp_height(input logic [HeightW-1:0] v);
    logic [HeightW-1:0] r;
    if (v == '0) r = HeightW'(1);
    else if (v > HeightW'(MaxHeight)) r = HeightW'(MaxHeight);
    else r = v;
    return r;
  endfunction

  // ceil(2^17 / s) for s = 1..16
  function automatic logic [RecipW-1:0] recip_scale(input logic [ScaleW-1:0] s);
    logic [RecipW-1:0] r;
    case (s)
      5'd1:    r = 18'd131072;
      5'd2:    r = 18'd65536;
      5'd3:    r = 18'd43691;
      5'd4:    r = 18'd32768;
      5'd5:    r = 18'd26215;
      5'd6:    r = 18'd21846;
      5'd7:    r = 18'd18725;
      5'd8:    r = 18'd16384;
      5'd9:    r = 18'd14564;
      5'd10:   r = 18'd13108;
      5'd11:   r = 18'd11916;
      5'd12:   r = 18'd10923;
      5'd13:   r = 18'd10083;
      5'd14:   r = 18'd9363;
      5'd15:   r = 18'd8739;
      default: r = 18'd8192;
    endcase
    return r;
  endfunction

  // ceil(2^24 / s^2) for s = 1..16
  function automatic logic [AvgRecipW-1:0] recip_area(input logic [ScaleW-1:0] s);
    logic [AvgRecipW-1:0] r;
    case (s)
      5'd1:    r = 25'd16777216;
      5'd2:    r = 25'd4194304;
      5'd3:    r = 25'd1864136;
      5'd4:    r = 25'd1048576;
      5'd5:    r = 25'd671089;
      5'd6:    r = 25'd466034;
      5'd7:    r = 25'd342393;
      5'd8:    r = 25'd262144;
      5'd9:    r = 25'd207127;
      5'd10:   r = 25'd167773;
      5'd11:   r = 25'd138655;
      5'd12:   r = 25'd116509;
      5'd13:   r = 25'd99274;
      5'd14:   r = 25'd85599;
      5'd15:   r = 25'd74566;
      default: r = 25'd65536;
    endcase
    return r;
  endfunction

endpackage

### hdl/ibad_ram.sv
module ibad_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ibad_core.sv
module ibad_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ibad_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ibad_pkg::PixW-1:0]     in_pixel_i,
  output ibad_pkg::res_t                res_o,
  input  logic                          res_ready_i,
  output logic                          mem_we_o,
  output logic [ibad_pkg::ColIdxW-1:0]  mem_addr_o,
  output logic [ibad_pkg::SumW-1:0]     mem_wdata_o,
  input  logic [ibad_pkg::SumW-1:0]     mem_rdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_OUT
  } state_e;

  localparam int unsigned PColW = ibad_pkg::ColW + ibad_pkg::RecipW;
  localparam int unsigned PRowW = ibad_pkg::RowW + ibad_pkg::RecipW;
  localparam int unsigned PWidW = ibad_pkg::WidthW + ibad_pkg::RecipW;
  localparam int unsigned PHgtW = ibad_pkg::HeightW + ibad_pkg::RecipW;
  localparam int unsigned PAvgW = ibad_pkg::SumW + ibad_pkg::AvgRecipW;
  localparam int unsigned K     = ibad_pkg::RecipK;

  state_e state_q, state_d;

  logic [ibad_pkg::ColW-1:0]    col_q, col_d;
  logic [ibad_pkg::RowW-1:0]    row_q, row_d;
  logic [ibad_pkg::SubW-1:0]    sub_col_q, sub_col_d;
  logic [ibad_pkg::SubW-1:0]    sub_row_q, sub_row_d;
  logic [ibad_pkg::RunW-1:0]    run_q, run_d;

  // Per-item working registers
  logic [ibad_pkg::PixW-1:0]    pix_q;
  logic [ibad_pkg::ScaleW-1:0]  s_q;
  logic [ibad_pkg::WidthW-1:0]  w_q;
  logic [ibad_pkg::HeightW-1:0] h_q;
  logic [PColW-1:0]             p_col_q;
  logic [PRowW-1:0]             p_row_q;
  logic [PWidW-1:0]             p_wid_q;
  logic [PHgtW-1:0]             p_hgt_q;
  logic [ibad_pkg::ColIdxW-1:0] bcol_q;
  logic                         last_q;
  logic                         row_first_q;
  logic                         row_done_q;
  logic [ibad_pkg::RunW-1:0]    rs_q;
  logic [PAvgW-1:0]             p_avg_q;

  logic [ibad_pkg::ScaleW-1:0]  s_in;
  logic [ibad_pkg::RecipW-1:0]  rcp_in;
  logic [ibad_pkg::ColW-1:0]    bcol;
  logic [ibad_pkg::RowW-1:0]    brow;
  logic [ibad_pkg::WidthW-1:0]  ocols_raw;
  logic [ibad_pkg::OutColW-1:0] ocols;
  logic [ibad_pkg::HeightW-1:0] orows;
  logic                         in_blk;
  logic                         col_done;
  logic                         blk_last;
  logic [ibad_pkg::RunW-1:0]    rs;
  logic [ibad_pkg::SumW-1:0]    total;
  logic                         accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign s_in   = ibad_pkg::clamp_scale(cfg_i.scale);
  assign rcp_in = ibad_pkg::recip_scale(s_in);

  // Block coordinates and reduced frame size from the registered products
  assign bcol      = p_col_q[K +: ibad_pkg::ColW];
  assign brow      = p_row_q[K +: ibad_pkg::RowW];
  assign ocols_raw = p_wid_q[K +: ibad_pkg::WidthW];
  assign orows     = p_hgt_q[K +: ibad_pkg::HeightW];
  assign ocols     = (ocols_raw > ibad_pkg::WidthW'(ibad_pkg::MaxOutCols))
                   ? ibad_pkg::OutColW'(ibad_pkg::MaxOutCols)
                   : ocols_raw[ibad_pkg::OutColW-1:0];

  assign in_blk   = ({1'b0, bcol} < ibad_pkg::WidthW'(ocols))
                 && ({1'b0, brow} < orows);
  assign col_done = ({1'b0, sub_col_q} + 5'd1) >= s_q;
  assign blk_last = (({1'b0, bcol} + 11'd1) == ibad_pkg::WidthW'(ocols))
                 && (({1'b0, brow} + 13'd1) == orows);
  assign rs       = ((sub_col_q == '0) ? '0 : run_q) + ibad_pkg::RunW'(pix_q);
  assign total    = (row_first_q ? '0 : mem_rdata_i) + ibad_pkg::SumW'(rs_q);

  assign mem_addr_o  = (state_q == ST_SUM) ? bcol_q : bcol[ibad_pkg::ColIdxW-1:0];
  assign mem_we_o    = (state_q == ST_SUM) && !row_done_q;
  assign mem_wdata_o = total;

  assign res_o.vld  = (state_q == ST_OUT);
  assign res_o.pix  = p_avg_q[ibad_pkg::AvgK +: ibad_pkg::PixW];
  assign res_o.last = last_q;

  // Counter advance, evaluated in ST_DIV with the latched frame size
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    sub_col_d = sub_col_q;
    sub_row_d = sub_row_q;
    run_d     = run_q;
    state_d   = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (in_blk) run_d = rs;
        if (({1'b0, col_q} + 11'd1) >= w_q) begin
          col_d     = '0;
          sub_col_d = '0;
          if (({1'b0, row_q} + 13'd1) >= h_q) begin
            row_d     = '0;
            sub_row_d = '0;
          end else begin
            row_d     = row_q + 12'd1;
            sub_row_d = ((({1'b0, sub_row_q} + 5'd1) >= s_q)) ? '0 : sub_row_q + 4'd1;
          end
        end else begin
          col_d     = col_q + 10'd1;
          sub_col_d = col_done ? '0 : sub_col_q + 4'd1;
        end
        state_d = (in_blk && col_done) ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        state_d = row_done_q ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      sub_col_q <= '0;
      sub_row_q <= '0;
      run_q     <= '0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      row_q     <= row_d;
      sub_col_q <= sub_col_d;
      sub_row_q <= sub_row_d;
      run_q     <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q   <= in_pixel_i;
      s_q     <= s_in;
      w_q     <= ibad_pkg::clamp_width(cfg_i.width);
      h_q     <= ibad_pkg::clamp_height(cfg_i.height);
      p_col_q <= PColW'(col_q) * PColW'(rcp_in);
      p_row_q <= PRowW'(row_q) * PRowW'(rcp_in);
      p_wid_q <= PWidW'(ibad_pkg::clamp_width(cfg_i.width)) * PWidW'(rcp_in);
      p_hgt_q <= PHgtW'(ibad_pkg::clamp_height(cfg_i.height)) * PHgtW'(rcp_in);
    end
    if (state_q == ST_DIV) begin
      bcol_q      <= bcol[ibad_pkg::ColIdxW-1:0];
      last_q      <= blk_last;
      row_first_q <= (sub_row_q == '0);
      row_done_q  <= ({1'b0, sub_row_q} + 5'd1) >= s_q;
      rs_q        <= rs;
    end
    if (state_q == ST_SUM) begin
      p_avg_q <= PAvgW'(total) * PAvgW'(ibad_pkg::recip_area(s_q));
    end
  end

endmodule

### hdl/image_box_average_downscale_unit.sv
// Box-average downscaler: pixels enter in raster order on the s_axis side, one
// 8-bit word each, and every whole scale-by-scale block leaves as one 8-bit word
// on the m_axis side holding the truncated block average; tlast marks the last
// block of the reduced frame. Columns and rows that do not fill a whole block
// are dropped, as are block columns beyond 64. Program image_width,
// image_height and scale_factor (register indexes 0, 1, 2) between pixels; a
// value of zero counts as one, and values above 1024, 4096 and 16 saturate
// after the data is cut to 11, 13 and 5 bits. Each pixel goes through ST_IDLE,
// which multiplies its position by the reciprocal of the scale as it is taken,
// and ST_DIV, which locates its block and reads the column-sum line store. A
// pixel that closes its row of a block then enters ST_SUM for the
// read-modify-write of the line store; when it also closes a block, ST_SUM
// forms the average by a reciprocal multiply instead, and ST_OUT hands the
// average to the output register, holding until the register frees up. The
// output register lets the next pixel in while a finished average waits on m_axis_tready.
module image_box_average_downscale_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ibad_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ibad_pkg::CfgDataW-1:0]   cfg_data_i,
  // pixel input
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] pixel_in
  // averaged output
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [7:0] pixel_out
  output logic                            m_axis_tlast    // frame_last
);

  ibad_pkg::cfg_t cfg_q;
  ibad_pkg::res_t res;

  logic                           out_valid_q;
  logic [ibad_pkg::PixW-1:0]      out_pix_q;
  logic                           out_last_q;
  logic                           out_free;

  logic                           mem_we;
  logic [ibad_pkg::ColIdxW-1:0]   mem_addr;
  logic [ibad_pkg::SumW-1:0]      mem_wdata;
  logic [ibad_pkg::SumW-1:0]      mem_rdata;

  // Register writes are always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= ibad_pkg::WidthReset;
      cfg_q.height <= ibad_pkg::HeightReset;
      cfg_q.scale  <= ibad_pkg::ScaleReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ibad_pkg::RegWidth:  cfg_q.width  <= cfg_data_i[ibad_pkg::WidthW-1:0];
        ibad_pkg::RegHeight: cfg_q.height <= cfg_data_i[ibad_pkg::HeightW-1:0];
        ibad_pkg::RegScale:  cfg_q.scale  <= cfg_data_i[ibad_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // Output register: load when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.vld) begin
      out_pix_q  <= res.pix;
      out_last_q <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

  ibad_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_pixel_i  (s_axis_tdata),
    .res_o       (res),
    .res_ready_i (out_free),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  // Line store of per-block-column partial sums
  ibad_ram #(
    .Width (ibad_pkg::SumW),
    .Depth (ibad_pkg::MaxOutCols)
  ) u_colsum (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule
